@@ design/phh_pkg.sv @@
// shared types and constants of the pair count hash histogram
package phh_pkg;

    localparam logic [1:0]  KIND_PUSH  = 2'd0;
    localparam logic [1:0]  KIND_QUERY = 2'd1;
    localparam logic [1:0]  KIND_DEC   = 2'd2;
    localparam logic [1:0]  KIND_CLEAR = 2'd3;

    localparam logic [31:0] HASH_MULT  = 32'd2654435761;
    localparam logic [14:0] COUNT_MAX  = 15'h7fff;

    typedef struct packed {
        logic [1:0]         kind;
        logic signed [15:0] sample;
        logic signed [15:0] pair_first;
        logic signed [15:0] pair_second;
    } in_word_t;

    typedef struct packed {
        logic [14:0] pair_count;
        logic        pair_found;
        logic        table_full;
        logic        count_saturated;
    } out_word_t;

    typedef struct packed {
        logic        valid;
        logic [15:0] first;
        logic [15:0] second;
        logic [14:0] count;
    } slot_t;

endpackage

@@ design/phh_stream_if.sv @@
// valid/ready word channel
interface phh_stream_if #(parameter type payload_t = logic);
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

@@ design/pair_count_hash_histogram_unit.sv @@
// hashed histogram of consecutive sample pairs, top level
//
// req carries one in_word_t per handshake: push a sample, query a pair,
// decrement a pair or clear the table. rsp returns one out_word_t for
// every accepted word, in order.
// all ways of a bucket sit in one word of a single memory with a
// registered read; each push or decrement does one read-modify-write of
// its bucket and each query one read, through the sequencer, one at a time.
// push, query and decrement go from acceptance through S_MUL, S_MOD,
// S_READ and S_UPD when BUCKETS is a power of two; otherwise S_DIV, S_REM
// and S_FIX follow S_MOD, where the bucket index comes from a reciprocal
// multiplication, a multiply back and one correcting subtraction.
// the result word is offered through the rsp output register after S_UPD.
// a push with no previous sample skips the memory and returns a zero result.
// clear sweeps the memory one bucket a cycle.
// after reset the same sweep runs with req.ready low.
// a finished result waits in the rsp output register while rsp.ready is
// low; the sequencer keeps req.ready low until the register frees.
module pair_count_hash_histogram_unit import phh_pkg::*; #(
    parameter int BUCKETS = 1024,
    parameter int WAYS    = 4
) (
    input  logic         clk,
    input  logic         rst_n,
    phh_stream_if.sink   req,
    phh_stream_if.source rsp
);

    localparam int          BW      = $clog2(BUCKETS);
    localparam bit          IS_POW2 = ((BUCKETS & (BUCKETS - 1)) == 0);
    localparam logic [31:0] RECIP   = 32'((64'd1 << 32) / 64'(BUCKETS));

    typedef enum logic [8:0] {
        S_CLEAR = 9'b000000001,
        S_IDLE  = 9'b000000010,
        S_MUL   = 9'b000000100,
        S_MOD   = 9'b000001000,
        S_DIV   = 9'b000010000,
        S_REM   = 9'b000100000,
        S_FIX   = 9'b001000000,
        S_READ  = 9'b010000000,
        S_UPD   = 9'b100000000
    } state_t;

    localparam state_t S_EMIT_DUMMY = S_IDLE;

    state_t      state_reg, state_next;
    logic        emit_reg, emit_next;
    logic        clr_emit_reg, clr_emit_next;
    logic [BW-1:0] clr_idx_reg, clr_idx_next;
    logic [15:0] prev_reg, prev_next;
    logic        have_prev_reg, have_prev_next;
    logic        out_valid_reg, out_valid_next;
    out_word_t   out_data_reg, out_data_next;

    logic [1:0]  kind_reg, kind_next;
    logic [15:0] a_reg, a_next;
    logic [15:0] b_reg, b_next;
    logic [31:0] prod_reg, prod_next;
    logic [31:0] sum_reg, sum_next;
    logic [31:0] quot_reg, quot_next;
    logic [31:0] rem_reg, rem_next;
    logic [BW-1:0] bucket_reg, bucket_next;
    out_word_t   res_reg, res_next;

    slot_t [WAYS-1:0] table_mem [BUCKETS];
    slot_t [WAYS-1:0] rd_data_reg;
    slot_t [WAYS-1:0] wr_data;
    logic [BW-1:0]    wr_addr;
    logic             wr_en;

    slot_t [WAYS-1:0] upd_word;
    logic             upd_we;
    out_word_t        upd_res;

    logic [31:0] sum_now;
    logic [63:0] recip_prod;
    logic [31:0] quot_times_n;
    logic        out_free;

    phh_bucket_update #(
        .WAYS (WAYS)
    ) u_update (
        .bucket_old (rd_data_reg),
        .kind       (kind_reg),
        .first      (a_reg),
        .second     (b_reg),
        .bucket_new (upd_word),
        .write_en   (upd_we),
        .result     (upd_res)
    );

    assign req.ready = (state_reg == S_IDLE) && !emit_reg;
    assign rsp.valid = out_valid_reg;
    assign rsp.data  = out_data_reg;

    assign sum_now      = prod_reg + {{16{b_reg[15]}}, b_reg};
    assign recip_prod   = 64'(sum_reg) * 64'(RECIP);
    assign quot_times_n = quot_reg * 32'(BUCKETS);
    assign out_free     = !out_valid_reg || rsp.ready;

    assign wr_en   = (state_reg == S_CLEAR) || ((state_reg == S_UPD) && upd_we);
    assign wr_addr = (state_reg == S_CLEAR) ? clr_idx_reg : bucket_reg;
    assign wr_data = (state_reg == S_CLEAR) ? '0 : upd_word;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            table_mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= table_mem[bucket_reg];
    end

    always_comb
    begin
        state_next     = state_reg;
        emit_next      = emit_reg;
        clr_emit_next  = clr_emit_reg;
        clr_idx_next   = clr_idx_reg;
        prev_next      = prev_reg;
        have_prev_next = have_prev_reg;
        out_valid_next = out_valid_reg && !rsp.ready;
        out_data_next  = out_data_reg;
        kind_next      = kind_reg;
        a_next         = a_reg;
        b_next         = b_reg;
        prod_next      = prod_reg;
        sum_next       = sum_reg;
        quot_next      = quot_reg;
        rem_next       = rem_reg;
        bucket_next    = bucket_reg;
        res_next       = res_reg;

        if (emit_reg && out_free)
        begin
            out_valid_next = 1'b1;
            out_data_next  = res_reg;
            emit_next      = 1'b0;
        end

        case (state_reg)
            S_CLEAR:
            begin
                clr_idx_next = clr_idx_reg + BW'(1);
                if (clr_idx_reg == BW'(BUCKETS - 1))
                begin
                    clr_idx_next = '0;
                    state_next   = S_IDLE;
                    if (clr_emit_reg)
                    begin
                        res_next      = '0;
                        emit_next     = 1'b1;
                        clr_emit_next = 1'b0;
                    end
                end
            end
            S_IDLE:
            begin
                if (req.valid && !emit_reg)
                begin
                    kind_next = req.data.kind;
                    if (req.data.kind == KIND_PUSH)
                    begin
                        a_next         = prev_reg;
                        b_next         = req.data.sample;
                        prev_next      = req.data.sample;
                        have_prev_next = 1'b1;
                        if (have_prev_reg)
                        begin
                            state_next = S_MUL;
                        end
                        else
                        begin
                            res_next  = '0;
                            emit_next = 1'b1;
                        end
                    end
                    else if (req.data.kind == KIND_CLEAR)
                    begin
                        prev_next      = '0;
                        have_prev_next = 1'b0;
                        clr_idx_next   = '0;
                        clr_emit_next  = 1'b1;
                        state_next     = S_CLEAR;
                    end
                    else
                    begin
                        a_next     = req.data.pair_first;
                        b_next     = req.data.pair_second;
                        state_next = S_MUL;
                    end
                end
            end
            S_MUL:
            begin
                prod_next  = {{16{a_reg[15]}}, a_reg} * HASH_MULT;
                state_next = S_MOD;
            end
            S_MOD:
            begin
                if (IS_POW2)
                begin
                    bucket_next = sum_now[BW-1:0];
                    state_next  = S_READ;
                end
                else
                begin
                    sum_next   = sum_now;
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                quot_next  = recip_prod[63:32];
                state_next = S_REM;
            end
            S_REM:
            begin
                rem_next   = sum_reg - quot_times_n;
                state_next = S_FIX;
            end
            S_FIX:
            begin
                bucket_next = (rem_reg >= 32'(BUCKETS)) ? BW'(rem_reg - 32'(BUCKETS))
                                                        : BW'(rem_reg);
                state_next  = S_READ;
            end
            S_READ:
            begin
                state_next = S_UPD;
            end
            S_UPD:
            begin
                res_next   = upd_res;
                emit_next  = 1'b1;
                state_next = S_EMIT_DUMMY;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            emit_reg      <= 1'b0;
            clr_emit_reg  <= 1'b0;
            clr_idx_reg   <= '0;
            prev_reg      <= '0;
            have_prev_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            emit_reg      <= emit_next;
            clr_emit_reg  <= clr_emit_next;
            clr_idx_reg   <= clr_idx_next;
            prev_reg      <= prev_next;
            have_prev_reg <= have_prev_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
        kind_reg     <= kind_next;
        a_reg        <= a_next;
        b_reg        <= b_next;
        prod_reg     <= prod_next;
        sum_reg      <= sum_next;
        quot_reg     <= quot_next;
        rem_reg      <= rem_next;
        bucket_reg   <= bucket_next;
        res_reg      <= res_next;
    end

endmodule

@@ design/phh_bucket_update.sv @@
// lookup, insert, increment and decrement over the ways of one bucket
module phh_bucket_update import phh_pkg::*; #(
    parameter int WAYS = 4
) (
    input  slot_t [WAYS-1:0] bucket_old,
    input  logic [1:0]       kind,
    input  logic [15:0]      first,
    input  logic [15:0]      second,
    output slot_t [WAYS-1:0] bucket_new,
    output logic             write_en,
    output out_word_t        result
);

    localparam int WW = (WAYS > 1) ? $clog2(WAYS) : 1;

    logic          hit;
    logic [WW-1:0] hit_idx;
    logic          has_free;
    logic [WW-1:0] free_idx;
    slot_t         sel;
    logic [14:0]   count_new;

    always_comb
    begin
        hit      = 1'b0;
        hit_idx  = '0;
        has_free = 1'b0;
        free_idx = '0;
        for (int w = WAYS - 1; w >= 0; w--)
        begin
            if (bucket_old[w].valid && bucket_old[w].first == first
                && bucket_old[w].second == second)
            begin
                hit     = 1'b1;
                hit_idx = WW'(w);
            end
            if (!bucket_old[w].valid)
            begin
                has_free = 1'b1;
                free_idx = WW'(w);
            end
        end
    end

    always_comb
    begin
        sel        = bucket_old[hit_idx];
        count_new  = sel.count;
        bucket_new = bucket_old;
        write_en   = 1'b0;
        result     = '0;
        case (kind)
            KIND_PUSH:
            begin
                write_en = 1'b1;
                if (hit)
                begin
                    if (sel.count == COUNT_MAX)
                    begin
                        result.count_saturated = 1'b1;
                    end
                    else
                    begin
                        count_new = sel.count + 15'd1;
                    end
                    bucket_new[hit_idx].count = count_new;
                    result.pair_count         = count_new;
                    result.pair_found         = 1'b1;
                end
                else if (has_free)
                begin
                    bucket_new[free_idx].valid  = 1'b1;
                    bucket_new[free_idx].first  = first;
                    bucket_new[free_idx].second = second;
                    bucket_new[free_idx].count  = 15'd1;
                    result.pair_count           = 15'd1;
                    result.pair_found           = 1'b1;
                end
                else
                begin
                    result.table_full = 1'b1;
                end
            end
            KIND_QUERY:
            begin
                if (hit)
                begin
                    result.pair_count = sel.count;
                    result.pair_found = 1'b1;
                end
            end
            KIND_DEC:
            begin
                write_en = hit;
                if (hit)
                begin
                    if (sel.count != 15'd0)
                    begin
                        count_new = sel.count - 15'd1;
                    end
                    bucket_new[hit_idx].count = count_new;
                    result.pair_count         = count_new;
                    result.pair_found         = 1'b1;
                end
            end
            default:
            begin
            end
        endcase
    end

endmodule
